/* rtl/hqs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqs_pkg
// Shared constants, types and the control store of the hybrid quicksort engine.
// ----------------------------------------------------------------------------
package hqs_pkg;

	localparam int DEPTH       = 64;
	localparam int STACK_DEPTH = 6;
	localparam int SMALL_RANGE = 3;
	localparam int VW          = 32;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int IW  = AW + 2;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PCW = 6;

	typedef logic signed [VW-1:0]  val_t;
	typedef logic signed [IW-1:0]  idx_t;
	typedef logic [CW-1:0]         cnt_t;
	typedef logic [SPW-1:0]        sp_t;
	typedef logic [PCW-1:0]        pc_t;

	typedef struct packed {
		logic [AW-1:0] lo;
		logic [AW-1:0] hi;
	} rng_t;

	typedef enum logic [4:0] {
		A_NOP,
		A_LOAD,
		A_INIT,
		A_RD_HI,
		A_PIVOT,
		A_RD_J,
		A_RD_K,
		A_WR_K_TMP,
		A_WR_J_RD,
		A_INC_J,
		A_WR_HI_RD,
		A_WR_K_PV,
		A_SPLIT,
		A_PUSH,
		A_INS_A,
		A_INS_B,
		A_INS_INIT,
		A_RD_I,
		A_KEY,
		A_RD_JM1,
		A_SHIFT,
		A_PUT,
		A_POP,
		A_OCLR,
		A_RD_O,
		A_OPUT,
		A_DONE
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_LASTACC,
		C_SMALL,
		C_J_GE_HI,
		C_RD_GT_PV,
		C_B_TRIVIAL,
		C_STK_FULL,
		C_I_GT_IHI,
		C_J_LE_ILO,
		C_RD_LE_KEY,
		C_FROMB,
		C_SP_ZERO,
		C_OFULL,
		C_O_LT_N
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   tgt;
	} ucw_t;

	// step addresses
	localparam pc_t S_IDLE  = 6'd0;
	localparam pc_t S_INIT  = 6'd1;
	localparam pc_t S_TOP   = 6'd2;
	localparam pc_t S_PRD   = 6'd3;
	localparam pc_t S_PPV   = 6'd4;
	localparam pc_t S_PLOOP = 6'd5;
	localparam pc_t S_PCMP  = 6'd6;
	localparam pc_t S_PSW   = 6'd7;
	localparam pc_t S_PSW2  = 6'd8;
	localparam pc_t S_PNEXT = 6'd9;
	localparam pc_t S_PFIN  = 6'd10;
	localparam pc_t S_PF1   = 6'd11;
	localparam pc_t S_PF2   = 6'd12;
	localparam pc_t S_PSEL  = 6'd13;
	localparam pc_t S_PCHK  = 6'd14;
	localparam pc_t S_PFULL = 6'd15;
	localparam pc_t S_PUSH  = 6'd16;
	localparam pc_t S_SMALL = 6'd17;
	localparam pc_t S_BINS  = 6'd18;
	localparam pc_t S_INS   = 6'd19;
	localparam pc_t S_IOUT  = 6'd20;
	localparam pc_t S_IKEY  = 6'd21;
	localparam pc_t S_IW    = 6'd22;
	localparam pc_t S_ICMP  = 6'd23;
	localparam pc_t S_ISH   = 6'd24;
	localparam pc_t S_IPUT  = 6'd25;
	localparam pc_t S_IEND  = 6'd26;
	localparam pc_t S_IPCHK = 6'd27;
	localparam pc_t S_POP   = 6'd28;
	localparam pc_t S_OUT0  = 6'd29;
	localparam pc_t S_ORD   = 6'd30;
	localparam pc_t S_OPUT  = 6'd31;
	localparam pc_t S_ONEXT = 6'd32;
	localparam pc_t S_DONE  = 6'd33;

	// control store: action, jump condition, jump target (else fall through)
	function automatic ucw_t ucode(input pc_t pc);
		ucw_t w;
		unique case (pc)
			S_IDLE:  w = '{A_LOAD,     C_NOT_LASTACC, S_IDLE};
			S_INIT:  w = '{A_INIT,     C_NEVER,       S_IDLE};
			S_TOP:   w = '{A_NOP,      C_SMALL,       S_SMALL};
			S_PRD:   w = '{A_RD_HI,    C_NEVER,       S_IDLE};
			S_PPV:   w = '{A_PIVOT,    C_NEVER,       S_IDLE};
			S_PLOOP: w = '{A_RD_J,     C_J_GE_HI,     S_PFIN};
			S_PCMP:  w = '{A_RD_K,     C_RD_GT_PV,    S_PNEXT};
			S_PSW:   w = '{A_WR_K_TMP, C_NEVER,       S_IDLE};
			S_PSW2:  w = '{A_WR_J_RD,  C_NEVER,       S_IDLE};
			S_PNEXT: w = '{A_INC_J,    C_ALWAYS,      S_PLOOP};
			S_PFIN:  w = '{A_RD_K,     C_NEVER,       S_IDLE};
			S_PF1:   w = '{A_WR_HI_RD, C_NEVER,       S_IDLE};
			S_PF2:   w = '{A_WR_K_PV,  C_NEVER,       S_IDLE};
			S_PSEL:  w = '{A_SPLIT,    C_NEVER,       S_IDLE};
			S_PCHK:  w = '{A_NOP,      C_B_TRIVIAL,   S_TOP};
			S_PFULL: w = '{A_NOP,      C_STK_FULL,    S_BINS};
			S_PUSH:  w = '{A_PUSH,     C_ALWAYS,      S_TOP};
			S_SMALL: w = '{A_INS_A,    C_ALWAYS,      S_INS};
			S_BINS:  w = '{A_INS_B,    C_NEVER,       S_IDLE};
			S_INS:   w = '{A_INS_INIT, C_NEVER,       S_IDLE};
			S_IOUT:  w = '{A_RD_I,     C_I_GT_IHI,    S_IEND};
			S_IKEY:  w = '{A_KEY,      C_NEVER,       S_IDLE};
			S_IW:    w = '{A_RD_JM1,   C_J_LE_ILO,    S_IPUT};
			S_ICMP:  w = '{A_NOP,      C_RD_LE_KEY,   S_IPUT};
			S_ISH:   w = '{A_SHIFT,    C_ALWAYS,      S_IW};
			S_IPUT:  w = '{A_PUT,      C_ALWAYS,      S_IOUT};
			S_IEND:  w = '{A_NOP,      C_FROMB,       S_TOP};
			S_IPCHK: w = '{A_NOP,      C_SP_ZERO,     S_OUT0};
			S_POP:   w = '{A_POP,      C_ALWAYS,      S_TOP};
			S_OUT0:  w = '{A_OCLR,     C_NEVER,       S_IDLE};
			S_ORD:   w = '{A_RD_O,     C_NEVER,       S_IDLE};
			S_OPUT:  w = '{A_OPUT,     C_OFULL,       S_OPUT};
			S_ONEXT: w = '{A_NOP,      C_O_LT_N,      S_ORD};
			S_DONE:  w = '{A_DONE,     C_ALWAYS,      S_IDLE};
			default: w = '{A_NOP,      C_ALWAYS,      S_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* rtl/hqs_elem_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqs_elem_if
// Input channel: one unsorted element per item, with a last mark.
// ----------------------------------------------------------------------------
interface hqs_elem_if import hqs_pkg::*; ;
	logic             valid;
	logic             ready;
	logic signed [VW-1:0] value;
	logic             last;

	modport source(output valid, output value, output last, input ready);
	modport sink(input valid, input value, input last, output ready);
endinterface

/* rtl/hqs_sorted_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqs_sorted_if
// Output channel: sorted elements, last mark and overflow flag.
// ----------------------------------------------------------------------------
interface hqs_sorted_if import hqs_pkg::*; ;
	logic             valid;
	logic             ready;
	logic signed [VW-1:0] value_res;
	logic             last_res;
	logic             overflowed;

	modport source(output valid, output value_res, output last_res, output overflowed,
		input ready);
	modport sink(input valid, input value_res, input last_res, input overflowed,
		output ready);
endinterface

/* rtl/hybrid_quicksort_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_quicksort_engine
// Buffers a set of signed elements and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   elem   : valid/ready input. Elements load one item per cycle while the
//            engine is idle; the item with last set closes the set. Elements
//            beyond DEPTH are dropped and the run is flagged as overflowed.
//   sorted : valid/ready output, one item per stored element, ascending,
//            last_res on the final one, overflowed on every item of a
//            flagged run.
// Operation:
//   After the last item a microcoded sequencer sorts in place over a
//   single-port element memory: quicksort with last-element pivot,
//   insertion sort on ranges of three or fewer and on any larger side
//   that the bounded range stack, when full, cannot take. Results then
//   leave one at a time, each after its own memory read. Loading of the
//   next set starts once the last result is registered.
// Reset clears the count, overflow flag, stack pointer, output valid and
// sequencer; memory contents are not cleared. A stalled receiver holds the
// output register and the sequencer waits on it; nothing is lost.
// ----------------------------------------------------------------------------
module hybrid_quicksort_engine import hqs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	hqs_elem_if.sink     elem,
	hqs_sorted_if.source sorted
);

	val_t mem [DEPTH];

	pc_t  pc_q;
	ucw_t uw;
	logic jump;

	cnt_t cnt_q;
	cnt_t o_q;
	logic ovf_q;
	sp_t  sp_q;
	sp_t  sp_m1;
	rng_t stk_q [STACK_DEPTH];

	idx_t lo_q, hi_q, i_q, j_q, k_q;
	idx_t blo_q, bhi_q, ilo_q, ihi_q;
	idx_t j_m1;
	logic fromb_q;
	val_t rd_q, pv_q, tmp_q, key_q;

	logic out_v_q;
	val_t out_val_q;
	logic out_last_q;
	logic out_ovf_q;
	logic ofull;

	logic acc;
	logic [AW-1:0] ra, wa;
	logic re, we;
	val_t wd;

	assign uw    = ucode(pc_q);
	assign sp_m1 = sp_q - sp_t'(1);
	assign j_m1  = j_q - idx_t'(1);
	assign ofull = out_v_q && !sorted.ready;

	assign elem.ready = (pc_q == S_IDLE);
	assign acc        = elem.valid && elem.ready;

	always_comb begin
		unique case (uw.cond)
			C_NEVER:       jump = 1'b0;
			C_ALWAYS:      jump = 1'b1;
			C_NOT_LASTACC: jump = !(acc && elem.last);
			C_SMALL:       jump = (hi_q - lo_q) <= idx_t'(SMALL_RANGE - 1);
			C_J_GE_HI:     jump = j_q >= hi_q;
			C_RD_GT_PV:    jump = rd_q > pv_q;
			C_B_TRIVIAL:   jump = bhi_q <= blo_q;
			C_STK_FULL:    jump = sp_q == sp_t'(STACK_DEPTH);
			C_I_GT_IHI:    jump = i_q > ihi_q;
			C_J_LE_ILO:    jump = j_q <= ilo_q;
			C_RD_LE_KEY:   jump = !(rd_q > key_q);
			C_FROMB:       jump = fromb_q;
			C_SP_ZERO:     jump = sp_q == '0;
			C_OFULL:       jump = ofull;
			C_O_LT_N:      jump = o_q < cnt_q;
			default:       jump = 1'b0;
		endcase
	end

	// memory port selection
	always_comb begin
		re = 1'b0;
		ra = j_q[AW-1:0];
		we = 1'b0;
		wa = j_q[AW-1:0];
		wd = rd_q;
		unique case (uw.act)
			A_LOAD: begin
				we = acc && (cnt_q < cnt_t'(DEPTH));
				wa = cnt_q[AW-1:0];
				wd = elem.value;
			end
			A_RD_HI: begin
				re = 1'b1;
				ra = hi_q[AW-1:0];
			end
			A_RD_J: begin
				re = 1'b1;
				ra = j_q[AW-1:0];
			end
			A_RD_K: begin
				re = 1'b1;
				ra = k_q[AW-1:0];
			end
			A_WR_K_TMP: begin
				we = 1'b1;
				wa = k_q[AW-1:0];
				wd = tmp_q;
			end
			A_WR_J_RD, A_SHIFT: begin
				we = 1'b1;
				wa = j_q[AW-1:0];
				wd = rd_q;
			end
			A_WR_HI_RD: begin
				we = 1'b1;
				wa = hi_q[AW-1:0];
				wd = rd_q;
			end
			A_WR_K_PV: begin
				we = 1'b1;
				wa = k_q[AW-1:0];
				wd = pv_q;
			end
			A_RD_I: begin
				re = 1'b1;
				ra = i_q[AW-1:0];
			end
			A_RD_JM1: begin
				re = 1'b1;
				ra = j_m1[AW-1:0];
			end
			A_PUT: begin
				we = 1'b1;
				wa = j_q[AW-1:0];
				wd = key_q;
			end
			A_RD_O: begin
				re = 1'b1;
				ra = o_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= S_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			sp_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			pc_q <= jump ? uw.tgt : pc_q + pc_t'(1);
			if (uw.act == A_OPUT && !ofull) begin
				out_v_q <= 1'b1;
			end else if (sorted.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (uw.act)
				A_LOAD: begin
					if (acc) begin
						if (cnt_q < cnt_t'(DEPTH)) begin
							cnt_q <= cnt_q + cnt_t'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				A_INIT: sp_q <= '0;
				A_PUSH: sp_q <= sp_q + sp_t'(1);
				A_POP:  sp_q <= sp_m1;
				A_DONE: begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (uw.act)
			A_INIT: begin
				lo_q <= '0;
				hi_q <= idx_t'({1'b0, cnt_q}) - idx_t'(1);
			end
			A_RD_HI: begin
				k_q <= lo_q;
				j_q <= lo_q;
			end
			A_PIVOT: pv_q <= rd_q;
			A_RD_K:  tmp_q <= rd_q;
			A_WR_J_RD: k_q <= k_q + idx_t'(1);
			A_INC_J:   j_q <= j_q + idx_t'(1);
			A_SPLIT: begin
				// smaller side next; larger side stacked, or sorted if stack full
				if ((k_q - lo_q) < (hi_q - k_q)) begin
					hi_q  <= k_q - idx_t'(1);
					blo_q <= k_q + idx_t'(1);
					bhi_q <= hi_q;
				end else begin
					lo_q  <= k_q + idx_t'(1);
					blo_q <= lo_q;
					bhi_q <= k_q - idx_t'(1);
				end
			end
			A_PUSH: begin
				stk_q[sp_q[SIW-1:0]] <= '{lo: blo_q[AW-1:0], hi: bhi_q[AW-1:0]};
			end
			A_INS_A: begin
				ilo_q   <= lo_q;
				ihi_q   <= hi_q;
				fromb_q <= 1'b0;
			end
			A_INS_B: begin
				ilo_q   <= blo_q;
				ihi_q   <= bhi_q;
				fromb_q <= 1'b1;
			end
			A_INS_INIT: i_q <= ilo_q + idx_t'(1);
			A_RD_I:     j_q <= i_q;
			A_KEY:      key_q <= rd_q;
			A_SHIFT:    j_q <= j_m1;
			A_PUT:      i_q <= i_q + idx_t'(1);
			A_POP: begin
				lo_q <= idx_t'({2'b00, stk_q[sp_m1[SIW-1:0]].lo});
				hi_q <= idx_t'({2'b00, stk_q[sp_m1[SIW-1:0]].hi});
			end
			A_OCLR: o_q <= '0;
			A_OPUT: begin
				if (!ofull) begin
					out_val_q  <= rd_q;
					out_last_q <= (o_q == cnt_q - cnt_t'(1));
					out_ovf_q  <= ovf_q;
					o_q        <= o_q + cnt_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign sorted.valid      = out_v_q;
	assign sorted.value_res  = out_val_q;
	assign sorted.last_res   = out_last_q;
	assign sorted.overflowed = out_ovf_q;

endmodule
